[sv/pstm_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pstm_pkg
// Shared constants for the polyphonic square tone mixer.
// ----------------------------------------------------------------------------
package pstm_pkg;

  localparam int NUM_VOICES = 4;
  localparam int VOICE_W    = (NUM_VOICES > 1) ? $clog2(NUM_VOICES) : 1;

  localparam int FREQ_W  = 16;
  localparam int LEVEL_W = 8;
  localparam int CH_W    = 2;
  localparam int VEL_W   = 8;
  localparam int DIV_CNT_W = $clog2(FREQ_W);

  localparam logic [FREQ_W-1:0] SAMPLE_RATE_RESET = 16'd40000;

  localparam logic COMMAND_TICK = 1'b0;
  localparam logic COMMAND_NOTE = 1'b1;

endpackage
`default_nettype wire

[sv/polyphonic_square_tone_mixer.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// polyphonic_square_tone_mixer
// Multi-voice square-wave mixer. A tick request is accepted, then a single
// shared phase unit sweeps the voices one per cycle, and then the output
// register is loaded. A set-note request with a nonzero frequency for an
// existing voice is accepted and then runs the bit-serial divider that forms
// period = sample_rate / tone_freq one quotient bit per cycle; a set-note with
// zero frequency or a channel beyond the voices completes in its accept cycle.
// One request is in work at a time; a finished level waits in the output
// register without holding up the next request, but a later tick holds in its
// last cycle until that register is free.
// ----------------------------------------------------------------------------
module polyphonic_square_tone_mixer (
  input  wire                           clk,
  input  wire                           rst,
  input  wire                           sample_rate_we,
  input  wire [pstm_pkg::FREQ_W-1:0]    sample_rate_wdata,
  input  wire                           cmd_valid,
  output logic                          cmd_ready,
  input  wire                           command,
  input  wire [pstm_pkg::CH_W-1:0]      channel,
  input  wire [pstm_pkg::FREQ_W-1:0]    tone_freq,
  input  wire [pstm_pkg::VEL_W-1:0]     velocity,
  output logic                          level_valid,
  input  wire                           level_ready,
  output logic [pstm_pkg::LEVEL_W-1:0]  level
);

  typedef enum logic [1:0] {IDLE, DIVIDE, SWEEP, EMIT} state_t;

  state_t state;

  logic [pstm_pkg::FREQ_W-1:0]  sample_rate;
  logic [pstm_pkg::FREQ_W-1:0]  period   [pstm_pkg::NUM_VOICES];
  logic [pstm_pkg::FREQ_W-1:0]  phase    [pstm_pkg::NUM_VOICES];
  logic [pstm_pkg::LEVEL_W-1:0] loudness [pstm_pkg::NUM_VOICES];

  // divider
  logic [pstm_pkg::FREQ_W-1:0]    rem;
  logic [pstm_pkg::FREQ_W-1:0]    quo;
  logic [pstm_pkg::FREQ_W-1:0]    divisor;
  logic [pstm_pkg::DIV_CNT_W-1:0] div_cnt;
  logic [pstm_pkg::VOICE_W-1:0]   div_voice;

  // sweep
  logic [pstm_pkg::VOICE_W-1:0]   vidx;
  logic [pstm_pkg::LEVEL_W-1:0]   sum;

  logic                           accept;
  logic                           emit_go;
  logic                           ch_ok;
  logic [pstm_pkg::VOICE_W+1:0]   ch_ext;
  logic [pstm_pkg::VOICE_W-1:0]   ch_idx;

  logic [pstm_pkg::FREQ_W:0]      trial;
  logic [pstm_pkg::FREQ_W+1:0]    diff;
  logic                           ge;
  logic [pstm_pkg::FREQ_W-1:0]    rem_next;

  logic [pstm_pkg::FREQ_W-1:0]    p_cur;
  logic [pstm_pkg::FREQ_W-1:0]    c_inc;
  logic [pstm_pkg::FREQ_W-1:0]    c_wrap;
  logic                           hit;
  logic [pstm_pkg::LEVEL_W:0]     sum_add;
  logic [pstm_pkg::LEVEL_W-1:0]   sum_next;

  assign cmd_ready = (state == IDLE);
  assign accept    = cmd_valid && cmd_ready;
  assign emit_go   = (state == EMIT) && (!level_valid || level_ready);
  assign ch_ok     = (32'(channel) < pstm_pkg::NUM_VOICES);
  assign ch_ext    = (pstm_pkg::VOICE_W + 2)'(channel);
  assign ch_idx    = ch_ext[pstm_pkg::VOICE_W-1:0];

  // restoring divide step: shift in the next dividend bit, try subtracting
  always_comb begin
    trial    = {rem, quo[pstm_pkg::FREQ_W-1]};
    diff     = {1'b0, trial} - (pstm_pkg::FREQ_W + 2)'(divisor);
    ge       = ~diff[pstm_pkg::FREQ_W+1];
    rem_next = ge ? diff[pstm_pkg::FREQ_W-1:0] : trial[pstm_pkg::FREQ_W-1:0];
  end

  // one voice per cycle: advance, wrap, and add loudness in the high half
  always_comb begin
    p_cur    = period[vidx];
    c_inc    = phase[vidx] + 16'd1;
    c_wrap   = (c_inc >= p_cur) ? '0 : c_inc;
    hit      = (p_cur != '0) && (c_wrap < (p_cur >> 1));
    sum_add  = {1'b0, sum} + {1'b0, loudness[vidx]};
    sum_next = sum;
    if (hit) begin
      sum_next = sum_add[pstm_pkg::LEVEL_W] ? '1 : sum_add[pstm_pkg::LEVEL_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= IDLE;
      sample_rate <= pstm_pkg::SAMPLE_RATE_RESET;
      level_valid <= 1'b0;
      vidx        <= '0;
      div_cnt     <= '0;
      for (int v = 0; v < pstm_pkg::NUM_VOICES; v++) begin
        period[v]   <= '0;
        phase[v]    <= '0;
        loudness[v] <= '0;
      end
    end else begin
      if (sample_rate_we) begin
        sample_rate <= sample_rate_wdata;
      end
      if (emit_go) begin
        level_valid <= 1'b1;
      end else if (level_valid && level_ready) begin
        level_valid <= 1'b0;
      end

      unique case (state)
        IDLE: begin
          if (accept) begin
            if (command == pstm_pkg::COMMAND_NOTE) begin
              if (ch_ok) begin
                loudness[ch_idx] <= pstm_pkg::LEVEL_W'(velocity / pstm_pkg::NUM_VOICES);
                if (tone_freq == '0) begin
                  period[ch_idx] <= '0;
                end else begin
                  divisor   <= tone_freq;
                  quo       <= sample_rate;
                  rem       <= '0;
                  div_cnt   <= '0;
                  div_voice <= ch_idx;
                  state     <= DIVIDE;
                end
              end
            end else begin
              vidx  <= '0;
              sum   <= '0;
              state <= SWEEP;
            end
          end
        end

        DIVIDE: begin
          rem     <= rem_next;
          quo     <= {quo[pstm_pkg::FREQ_W-2:0], ge};
          div_cnt <= div_cnt + 1'b1;
          if (div_cnt == pstm_pkg::DIV_CNT_W'(pstm_pkg::FREQ_W - 1)) begin
            period[div_voice] <= {quo[pstm_pkg::FREQ_W-2:0], ge};
            state             <= IDLE;
          end
        end

        SWEEP: begin
          if (p_cur != '0) begin
            phase[vidx] <= c_wrap;
          end
          sum  <= sum_next;
          vidx <= vidx + 1'b1;
          if (vidx == pstm_pkg::VOICE_W'(pstm_pkg::NUM_VOICES - 1)) begin
            state <= EMIT;
          end
        end

        EMIT: begin
          // hold until the output register is free
          if (emit_go) begin
            level <= sum;
            state <= IDLE;
          end
        end

        default: state <= IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

[sv/pstm_checker.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pstm_checker
// Port-level checks for the polyphonic square tone mixer.
// ----------------------------------------------------------------------------
module pstm_checker (
  input wire                           clk,
  input wire                           rst,
  input wire                           cmd_valid,
  input wire                           cmd_ready,
  input wire                           command,
  input wire                           level_valid,
  input wire                           level_ready,
  input wire [pstm_pkg::LEVEL_W-1:0]   level
);

  // a stalled level holds its value
  a_level_hold: assert property (@(posedge clk) disable iff (rst)
    level_valid && !level_ready |=> level_valid && $stable(level))
    else $error("level changed or dropped while stalled");

  // reset empties the output register
  a_reset_empty: assert property (@(posedge clk)
    $past(rst) |-> !level_valid)
    else $error("level valid right after reset");

  // a tick keeps the block busy through the sweep
  a_tick_busy: assert property (@(posedge clk) disable iff (rst)
    cmd_valid && cmd_ready && (command == pstm_pkg::COMMAND_TICK) |=> !cmd_ready)
    else $error("ready right after a tick request");

  // a set-note never produces a level
  a_note_silent: assert property (@(posedge clk) disable iff (rst)
    cmd_valid && cmd_ready && (command == pstm_pkg::COMMAND_NOTE) && !level_valid
    |=> !level_valid)
    else $error("level produced by a set-note request");

endmodule

bind polyphonic_square_tone_mixer pstm_checker u_pstm_checker (.*);
`default_nettype wire
